// ===== sv/dlp_pkg.sv =====
// ----------------------------------------------------------------------------
// dlp_pkg
// Shared sizes and types for the longest-path-from-source block.
// ----------------------------------------------------------------------------
package dlp_pkg;
    localparam int NODES     = 64;
    localparam int MAXN      = (NODES < 64) ? NODES : 64;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int LEN_W     = 7;

    localparam logic REQ_ADD_EDGE = 1'b0;
    localparam logic REQ_QUERY    = 1'b1;

    typedef logic [MAXN-1:0]  row_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [LEN_W-1:0] len_t;

    // Depth-first stack entry: resume position above, node below.
    typedef logic [CNT_W+IDX_W-1:0] stack_t;

    // Next set bit at or above a start position, for the neighbor search.
    typedef struct packed {
        logic found;
        idx_t pos;
    } scan_t;
endpackage

// ===== sv/dlp_scan.sv =====
// ----------------------------------------------------------------------------
// dlp_scan
// Shared search unit: lowest set bit of a row at or above a start index.
// ----------------------------------------------------------------------------
module dlp_scan
(
    input  dlp_pkg::row_t  row,
    input  dlp_pkg::cnt_t  start,
    output dlp_pkg::scan_t result
);
    dlp_pkg::row_t masked;
    dlp_pkg::row_t lowest;

    always_comb
    begin
        masked = '0;
        for (int i = 0; i < dlp_pkg::MAXN; i++)
        begin
            masked[i] = row[i] && (dlp_pkg::cnt_t'(i) >= start);
        end
        // Isolate the lowest set bit, then encode it.
        lowest = masked & (~masked + dlp_pkg::row_t'(1));
        result.found = |masked;
        result.pos   = '0;
        for (int i = 0; i < dlp_pkg::MAXN; i++)
        begin
            if (lowest[i])
            begin
                result.pos = result.pos | dlp_pkg::idx_t'(i);
            end
        end
    end
endmodule

// ===== sv/dag_longest_path_from_source_core.sv =====
// ----------------------------------------------------------------------------
// dag_longest_path_from_source_core
// An edge item reads the tail's row, then writes it back with the head's bit
// set; the input stays stalled for the write. A query over N nodes in use runs a
// depth-first walk for the finish order, relaxes the reached nodes and the edges
// leaving them in reverse finish order, then sends N results, held through output
// stalls. One item at a time; the next is taken once the last one is done.
// Reset: async, active low; node_count returns to 64, then a clearing pass
// zeroes the adjacency rows before the first item is taken.
// ----------------------------------------------------------------------------
module dag_longest_path_from_source_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [5:0] from_node,
    input  logic [5:0] to_node,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [5:0] node_index,
    output logic [5:0] distance,
    output logic       unreachable,
    output logic       last_result
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_EDGE_WR, S_ROOT, S_DFS_STEP, S_DFS_RD, S_REL_INIT,
        S_REL_PICK, S_REL_TOPO, S_REL_LEN, S_REL_SCAN, S_REL_UPD, S_EMIT_RD,
        S_EMIT_OUT, S_EMIT_HOLD
    } state_t;

    state_t state_reg;
    logic [6:0] node_count_reg;

    // Scratch and adjacency memories, one port each, registered read data.
    dlp_pkg::row_t   adj_mem   [dlp_pkg::MAXN];
    dlp_pkg::idx_t   topo_mem  [dlp_pkg::MAXN];
    dlp_pkg::stack_t stack_mem [dlp_pkg::MAXN];
    dlp_pkg::len_t   len_mem   [dlp_pkg::MAXN];

    dlp_pkg::row_t   adj_rd;
    dlp_pkg::idx_t   topo_rd;
    dlp_pkg::stack_t stack_rd;
    dlp_pkg::len_t   len_rd;

    logic            adj_re;
    logic            adj_we;
    dlp_pkg::idx_t   adj_addr;
    dlp_pkg::row_t   adj_wdata;
    logic            topo_we;
    dlp_pkg::idx_t   topo_addr;
    logic            stack_we;
    dlp_pkg::idx_t   stack_addr;
    dlp_pkg::stack_t stack_wdata;
    logic            len_we;
    dlp_pkg::idx_t   len_addr;
    dlp_pkg::len_t   len_wdata;

    dlp_pkg::idx_t clr_reg;
    dlp_pkg::idx_t from_reg;
    dlp_pkg::idx_t to_reg;
    dlp_pkg::row_t visited_reg;
    dlp_pkg::row_t reached_reg;
    dlp_pkg::cnt_t n_reg;
    dlp_pkg::row_t inuse_reg;
    dlp_pkg::idx_t src_reg;
    logic          src_ok_reg;
    dlp_pkg::cnt_t root_reg;
    dlp_pkg::cnt_t sp_reg;
    dlp_pkg::cnt_t cnt_reg;
    dlp_pkg::idx_t v_reg;
    dlp_pkg::cnt_t nx_reg;
    dlp_pkg::len_t nd_reg;
    dlp_pkg::cnt_t k_reg;
    dlp_pkg::cnt_t u_reg;
    dlp_pkg::idx_t pos_reg;

    logic [5:0] node_index_reg;
    logic [5:0] distance_reg;
    logic       unreachable_reg;
    logic       last_result_reg;
    logic       out_valid_reg;

    dlp_pkg::row_t  scan_row;
    dlp_pkg::cnt_t  scan_start;
    dlp_pkg::scan_t scan_res;
    dlp_pkg::cnt_t  n_eff;
    dlp_pkg::row_t  inuse_next;
    dlp_pkg::row_t  reached_next;

    // Clamp node_count into the supported range.
    always_comb
    begin
        if (node_count_reg == 7'd0)
        begin
            n_eff = dlp_pkg::cnt_t'(1);
        end
        else if (node_count_reg > dlp_pkg::cnt_t'(dlp_pkg::MAXN))
        begin
            n_eff = dlp_pkg::cnt_t'(dlp_pkg::MAXN);
        end
        else
        begin
            n_eff = node_count_reg;
        end
    end

    // Mask of nodes in use for a new query; seed of the reached set.
    always_comb
    begin
        for (int i = 0; i < dlp_pkg::MAXN; i++)
        begin
            inuse_next[i] = dlp_pkg::cnt_t'(i) < n_eff;
        end
        reached_next = '0;
        if (src_ok_reg)
        begin
            reached_next[src_reg] = 1'b1;
        end
    end

    // The one search unit serves the walk and the relaxation. The row
    // register holds the adjacency row of the node being worked on.
    always_comb
    begin
        if (state_reg == S_DFS_STEP)
        begin
            scan_row   = adj_rd & inuse_reg & ~visited_reg;
            scan_start = nx_reg;
        end
        else
        begin
            scan_row   = adj_rd & inuse_reg;
            scan_start = u_reg;
        end
    end

    dlp_scan u_scan
    (
        .row    (scan_row),
        .start  (scan_start),
        .result (scan_res)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign node_index  = node_index_reg;
    assign distance    = distance_reg;
    assign unreachable = unreachable_reg;
    assign last_result = last_result_reg;

    // Memory addresses and write strobes for each state.
    always_comb
    begin
        adj_re      = 1'b0;
        adj_we      = 1'b0;
        adj_addr    = v_reg;
        adj_wdata   = '0;
        topo_we     = 1'b0;
        topo_addr   = cnt_reg[5:0];
        stack_we    = 1'b0;
        stack_addr  = dlp_pkg::idx_t'(sp_reg - 7'd1);
        stack_wdata = {7'(scan_res.pos) + 7'd1, v_reg};
        len_we      = 1'b0;
        len_addr    = k_reg[5:0];
        len_wdata   = nd_reg;
        case (state_reg)
            S_CLEAR:
            begin
                adj_we   = 1'b1;
                adj_addr = clr_reg;
            end
            S_IDLE:
            begin
                // Fetch the tail's row in case this is an edge item.
                adj_re   = 1'b1;
                adj_addr = from_node;
            end
            S_EDGE_WR:
            begin
                adj_we    = 1'b1;
                adj_addr  = from_reg;
                adj_wdata = adj_rd | (dlp_pkg::row_t'(1) << to_reg);
            end
            S_ROOT:
            begin
                adj_re   = 1'b1;
                adj_addr = root_reg[5:0];
            end
            S_DFS_STEP:
            begin
                if (scan_res.found && sp_reg < 7'd64)
                begin
                    // Save the resume point of v, fetch the child's row.
                    stack_we = 1'b1;
                    adj_re   = 1'b1;
                    adj_addr = scan_res.pos;
                end
                else
                begin
                    // Record v as finished, read the parent entry.
                    topo_we    = 1'b1;
                    stack_addr = dlp_pkg::idx_t'(sp_reg - 7'd2);
                end
            end
            S_DFS_RD:
            begin
                adj_re   = 1'b1;
                adj_addr = stack_rd[5:0];
            end
            S_REL_INIT:
            begin
                len_we    = src_ok_reg;
                len_addr  = src_reg;
                len_wdata = '0;
            end
            S_REL_PICK:
            begin
                topo_addr = dlp_pkg::idx_t'(k_reg - 7'd1);
            end
            S_REL_TOPO:
            begin
                adj_re   = 1'b1;
                adj_addr = topo_rd;
                len_addr = topo_rd;
            end
            S_REL_SCAN:
            begin
                len_addr = scan_res.pos;
            end
            S_REL_UPD:
            begin
                len_we   = !reached_reg[pos_reg] || len_rd < nd_reg;
                len_addr = pos_reg;
            end
            default:
            begin
                adj_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_addr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd <= adj_mem[adj_addr];
        end
        if (topo_we)
        begin
            topo_mem[topo_addr] <= v_reg;
        end
        topo_rd <= topo_mem[topo_addr];
        if (stack_we)
        begin
            stack_mem[stack_addr] <= stack_wdata;
        end
        stack_rd <= stack_mem[stack_addr];
        if (len_we)
        begin
            len_mem[len_addr] <= len_wdata;
        end
        len_rd <= len_mem[len_addr];
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            node_count_reg  <= 7'd64;
            clr_reg         <= '0;
            from_reg        <= '0;
            to_reg          <= '0;
            visited_reg     <= '0;
            reached_reg     <= '0;
            n_reg           <= '0;
            inuse_reg       <= '0;
            src_reg         <= '0;
            src_ok_reg      <= 1'b0;
            root_reg        <= '0;
            sp_reg          <= '0;
            cnt_reg         <= '0;
            v_reg           <= '0;
            nx_reg          <= '0;
            nd_reg          <= '0;
            k_reg           <= '0;
            u_reg           <= '0;
            pos_reg         <= '0;
            node_index_reg  <= '0;
            distance_reg    <= '0;
            unreachable_reg <= 1'b0;
            last_result_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    // Zero one adjacency row per cycle.
                    clr_reg <= clr_reg + 6'd1;
                    if (clr_reg == dlp_pkg::idx_t'(dlp_pkg::MAXN - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (req_type == dlp_pkg::REQ_ADD_EDGE)
                        begin
                            // Drop edges that leave the nodes in use.
                            if (dlp_pkg::cnt_t'(from_node) < n_eff
                                && dlp_pkg::cnt_t'(to_node) < n_eff)
                            begin
                                from_reg  <= from_node;
                                to_reg    <= to_node;
                                state_reg <= S_EDGE_WR;
                            end
                        end
                        else
                        begin
                            n_reg       <= n_eff;
                            inuse_reg   <= inuse_next;
                            src_reg     <= from_node;
                            src_ok_reg  <= dlp_pkg::cnt_t'(from_node) < n_eff;
                            visited_reg <= '0;
                            root_reg    <= '0;
                            cnt_reg     <= '0;
                            state_reg   <= S_ROOT;
                        end
                    end
                end
                S_EDGE_WR:
                begin
                    state_reg <= S_IDLE;
                end
                S_ROOT:
                begin
                    if (root_reg == n_reg)
                    begin
                        state_reg <= S_REL_INIT;
                    end
                    else if (visited_reg[root_reg[5:0]])
                    begin
                        root_reg <= root_reg + 7'd1;
                    end
                    else
                    begin
                        // Start a new tree; its row arrives next cycle.
                        visited_reg[root_reg[5:0]] <= 1'b1;
                        v_reg     <= root_reg[5:0];
                        nx_reg    <= '0;
                        sp_reg    <= 7'd1;
                        state_reg <= S_DFS_STEP;
                    end
                end
                S_DFS_STEP:
                begin
                    if (scan_res.found && sp_reg < 7'd64)
                    begin
                        // Descend into the lowest unvisited neighbor.
                        visited_reg[scan_res.pos] <= 1'b1;
                        v_reg  <= scan_res.pos;
                        nx_reg <= '0;
                        sp_reg <= sp_reg + 7'd1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                        sp_reg  <= sp_reg - 7'd1;
                        if (sp_reg == 7'd1)
                        begin
                            root_reg  <= root_reg + 7'd1;
                            state_reg <= S_ROOT;
                        end
                        else
                        begin
                            state_reg <= S_DFS_RD;
                        end
                    end
                end
                S_DFS_RD:
                begin
                    // Resume the parent where its search stopped.
                    v_reg     <= stack_rd[5:0];
                    nx_reg    <= stack_rd[12:6];
                    state_reg <= S_DFS_STEP;
                end
                S_REL_INIT:
                begin
                    reached_reg <= reached_next;
                    k_reg       <= cnt_reg;
                    state_reg   <= S_REL_PICK;
                end
                S_REL_PICK:
                begin
                    // Walk the finish order backward; topo read is issued here.
                    if (k_reg == 7'd0)
                    begin
                        state_reg <= S_EMIT_RD;
                    end
                    else
                    begin
                        state_reg <= S_REL_TOPO;
                    end
                end
                S_REL_TOPO:
                begin
                    v_reg <= topo_rd;
                    k_reg <= k_reg - 7'd1;
                    if (reached_reg[topo_rd])
                    begin
                        state_reg <= S_REL_LEN;
                    end
                    else
                    begin
                        state_reg <= S_REL_PICK;
                    end
                end
                S_REL_LEN:
                begin
                    nd_reg    <= (len_rd == 7'd127) ? 7'd127 : len_rd + 7'd1;
                    u_reg     <= '0;
                    state_reg <= S_REL_SCAN;
                end
                S_REL_SCAN:
                begin
                    if (!scan_res.found)
                    begin
                        state_reg <= S_REL_PICK;
                    end
                    else
                    begin
                        pos_reg   <= scan_res.pos;
                        u_reg     <= 7'(scan_res.pos) + 7'd1;
                        state_reg <= S_REL_UPD;
                    end
                end
                S_REL_UPD:
                begin
                    // Length of the neighbor is in len_rd; raise it if shorter.
                    if (!reached_reg[pos_reg] || len_rd < nd_reg)
                    begin
                        reached_reg[pos_reg] <= 1'b1;
                    end
                    state_reg <= S_REL_SCAN;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    node_index_reg  <= k_reg[5:0];
                    unreachable_reg <= !reached_reg[k_reg[5:0]];
                    distance_reg    <= !reached_reg[k_reg[5:0]] ? 6'd0 :
                                       (len_rd > 7'd63) ? 6'd63 : len_rd[5:0];
                    last_result_reg <= (k_reg + 7'd1 == n_reg);
                    out_valid_reg   <= 1'b1;
                    state_reg       <= S_EMIT_HOLD;
                end
                S_EMIT_HOLD:
                begin
                    // Hold the item until the receiver takes it.
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        if (k_reg + 7'd1 == n_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 7'd1;
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks on the sequencer.
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("item taken while results pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(node_index)
            && $stable(distance) && $stable(unreachable) && $stable(last_result)))
        else $error("stalled result changed");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_result && !out_stall) |=> (state_reg == S_IDLE))
        else $error("last result not at end of query");
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!out_valid && in_stall))
        else $error("activity during clearing pass");
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks dag_longest_path_from_source_core against a local longest-path
// predictor: edges and queries are sent with random gaps, results are checked
// field by field, in order, across several node_count settings.
// ----------------------------------------------------------------------------
module tb;
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [6:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       req_type = dlp_pkg::REQ_ADD_EDGE;
    logic [5:0] from_node = '0;
    logic [5:0] to_node = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [5:0] node_index;
    logic [5:0] distance;
    logic       unreachable;
    logic       last_result;

    typedef struct packed {
        logic [5:0] node;
        logic [5:0] span;
        logic       unr;
        logic       last;
    } path_result_t;

    // Shadow copy of the block state
    logic [63:0]  graph_rows [64];
    logic [6:0]   cfg_nodes;
    path_result_t pending_paths [$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           queries_sent = 0;
    int           edges_sent = 0;

    dag_longest_path_from_source_core dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
        .from_node(from_node), .to_node(to_node), .out_valid(out_valid),
        .out_stall(out_stall), .node_index(node_index), .distance(distance),
        .unreachable(unreachable), .last_result(last_result)
    );

    always #6 clk = ~clk;

    function automatic int active_nodes();
        int n;
        begin
            n = int'(cfg_nodes);
            if (n < 1) n = 1;
            if (n > dlp_pkg::MAXN) n = dlp_pkg::MAXN;
            return n;
        end
    endfunction

    // Predict the results of one item and queue them
    task automatic predict_item(input logic rt, input logic [5:0] src, input logic [5:0] dst);
        int n, cnt, sp, r, k, u, v, nx, nd;
        logic [63:0] inuse, seen, reached, row;
        logic [5:0]  order [64];
        logic [12:0] stack [64];
        int          plen [64];
        path_result_t pr;
        begin
            n = active_nodes();
            inuse = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            if (rt == dlp_pkg::REQ_ADD_EDGE) begin
                if (src < n && dst < n) graph_rows[src][dst] = 1'b1;
                return;
            end
            cnt = 0;
            seen = '0;
            for (r = 0; r < n; r++) begin
                if (seen[r]) continue;
                seen[r] = 1'b1;
                stack[0] = 13'(r);
                sp = 1;
                while (sp > 0) begin
                    v = int'(stack[sp-1][5:0]);
                    nx = int'(stack[sp-1][12:6]);
                    row = graph_rows[v] & inuse;
                    u = nx;
                    while (u < n && (!row[u] || seen[u])) u++;
                    if (u < n && sp < 64) begin
                        stack[sp-1] = {7'(u + 1), 6'(v)};
                        seen[u] = 1'b1;
                        stack[sp] = 13'(u);
                        sp++;
                    end
                    else begin
                        sp--;
                        if (cnt < 64) begin
                            order[cnt] = 6'(v);
                            cnt++;
                        end
                    end
                end
            end
            for (k = 0; k < 64; k++) plen[k] = 0;
            reached = '0;
            if (src < n) reached[src] = 1'b1;
            for (k = cnt; k > 0; k--) begin
                v = int'(order[k-1]);
                if (!reached[v]) continue;
                row = graph_rows[v] & inuse;
                nd = plen[v] + 1;
                if (nd > 127) nd = 127;
                for (u = 0; u < n; u++) begin
                    if (!row[u]) continue;
                    if (!reached[u] || plen[u] < nd) begin
                        plen[u] = nd;
                        reached[u] = 1'b1;
                    end
                end
            end
            for (k = 0; k < n; k++) begin
                pr.node = 6'(k);
                pr.unr = !reached[k];
                pr.span = reached[k] ? ((plen[k] > 63) ? 6'd63 : 6'(plen[k])) : 6'd0;
                pr.last = (k + 1 == n);
                pending_paths.insert(pending_paths.size(), pr);
            end
        end
    endtask

    // Send one item after a random gap; hold it until accepted
    task automatic send_item(input logic rt, input logic [5:0] src, input logic [5:0] dst);
        int gap;
        begin
            gap = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            predict_item(rt, src, dst);
            if (rt == dlp_pkg::REQ_QUERY) queries_sent++;
            else edges_sent++;
            in_valid <= 1'b1;
            req_type <= rt;
            from_node <= src;
            to_node <= dst;
            @(posedge clk);
            while (in_stall) @(posedge clk);
        end
    endtask

    // Wait for the block to drain, then write node_count
    task automatic set_nodes(input logic [6:0] value);
        begin
            in_valid <= 1'b0;
            while (pending_paths.size() != 0) @(posedge clk);
            repeat (8) @(posedge clk);
            cfg_we <= 1'b1;
            cfg_wdata <= value;
            @(posedge clk);
            cfg_we <= 1'b0;
            cfg_nodes = value;
        end
    endtask

    // Receiver stall: hold for a random number of cycles per item
    initial begin
        int hold;
        forever begin
            hold = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) hold = 0;
            out_stall <= (hold != 0);
            repeat (hold) @(posedge clk);
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        path_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (pending_paths.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result node=%0d dist=%0d", node_index, distance);
            end
            else begin
                want = pending_paths.pop_front();
                if (want != {node_index, distance, unreachable, last_result}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp node=%0d dist=%0d unr=%0b last=%0b got %0d %0d %0b %0b",
                            want.node, want.span, want.unr, want.last,
                            node_index, distance, unreachable, last_result);
                end
            end
        end
    end

    // Chain, full edge extremes, out-of-range and unreachable cases
    task automatic test_directed();
        int i;
        begin
            send_item(dlp_pkg::REQ_QUERY, 6'd0, 6'd0);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd0, 6'd1);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd1, 6'd2);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd0, 6'd2);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd2, 6'd63);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd62, 6'd63);
            send_item(dlp_pkg::REQ_QUERY, 6'd0, 6'h3F);
            send_item(dlp_pkg::REQ_QUERY, 6'd63, 6'd0);
            set_nodes(7'd8);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd9, 6'd3);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd3, 6'd40);
            send_item(dlp_pkg::REQ_QUERY, 6'd1, 6'd0);
            send_item(dlp_pkg::REQ_QUERY, 6'd20, 6'd0);
            set_nodes(7'd0);
            send_item(dlp_pkg::REQ_QUERY, 6'd0, 6'd0);
            set_nodes(7'd127);
            send_item(dlp_pkg::REQ_QUERY, 6'd2, 6'd0);
            // long chain to exercise deep stack
            set_nodes(7'd64);
            for (i = 3; i < 63; i++) send_item(dlp_pkg::REQ_ADD_EDGE, 6'(i), 6'(i + 1));
            send_item(dlp_pkg::REQ_QUERY, 6'd0, 6'd0);
        end
    endtask

    // Clear the shadow graph is impossible, so random graphs grow on the chain;
    // use small node counts mostly to keep queries short
    task automatic test_random();
        int ph, i, n, a, b;
        begin
            for (ph = 0; ph < 6; ph++) begin
                case (ph)
                    0: n = 1;
                    1: n = 5;
                    2: n = 12;
                    3: n = 16;
                    4: n = 64;
                    default: n = 2;
                endcase
                set_nodes(7'(n));
                for (i = 0; i < 10; i++) begin
                    if ($urandom_range(0, 4) == 0) begin
                        send_item(dlp_pkg::REQ_QUERY, 6'($urandom_range(0, 63)), 6'($urandom));
                    end
                    else if ($urandom_range(0, 6) == 0) begin
                        send_item(dlp_pkg::REQ_ADD_EDGE, 6'($urandom), 6'($urandom));
                    end
                    else begin
                        // forward edges keep the graph acyclic
                        a = $urandom_range(0, (n > 1) ? n - 2 : 0);
                        b = $urandom_range(a + 1, (n > 1) ? n - 1 : 1);
                        send_item(dlp_pkg::REQ_ADD_EDGE, 6'(a), 6'(b));
                    end
                end
                send_item(dlp_pkg::REQ_QUERY, 6'($urandom_range(0, (n > 1) ? n - 1 : 0)), 6'd0);
            end
            // a few back edges to hit the cycle handling
            set_nodes(7'd6);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd5, 6'd0);
            send_item(dlp_pkg::REQ_ADD_EDGE, 6'd4, 6'd1);
            send_item(dlp_pkg::REQ_QUERY, 6'd0, 6'd0);
            send_item(dlp_pkg::REQ_QUERY, 6'd3, 6'd0);
        end
    endtask

    initial begin
        #(12 * 3000000);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < 64; k++) graph_rows[k] = '0;
        cfg_nodes = 7'd64;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random();
        in_valid <= 1'b0;
        while (pending_paths.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d edges and %0d queries; checked %0d node results.",
            edges_sent, queries_sent, results_seen);
        if (mismatches == 0) begin
            $display("All tests passed");
        end
        else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// ===== dag_longest_path_from_source_core.f =====
sv/dlp_pkg.sv
sv/dlp_scan.sv
sv/dag_longest_path_from_source_core.sv
bench/tb.sv
